>>> rtl/utf8_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// check that holds outside reset
`define UTF8D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utf8 decoder check failed");
// check that also holds across reset
`define UTF8D_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("utf8 decoder reset check failed");
`else
`define UTF8D_ASSERT(lbl, clk, rst, prop)
`define UTF8D_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Result record, status codes and byte classification constants.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_TRUNC   = 2'd2
   } status_type;

   // one decoded character
   typedef struct packed {
      logic       run_end;
      status_type status;
      logic       is_target;
      logic [2:0] byte_length;
      logic [15:0] start_offset;
      logic [15:0] char_position;
      logic [20:0] code_point;
   } result_type;

   // results produced by one request
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } decode_out_type;

   localparam logic [7:0] LEAD_C0  = 8'hC0;
   localparam logic [7:0] LEAD_C1  = 8'hC1;
   localparam logic [7:0] LEAD_MAX = 8'hF4;

endpackage

>>> rtl/utf8d_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 byte decoder
// Holds the partial character and counters; turns one byte into up to two
// finished characters in a single pass.
// ----------------------------------------------------------------------------
module utf8d_decode #(
   parameter logic [15:0] COUNT_CAP = 16'hFFFF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    first_byte,
   input  logic                    last_byte,
   input  logic [15:0]             target_index,
   output utf8d_pkg::decode_out_type dec_out
);
   import utf8d_pkg::*;

   logic [1:0]  pend_ff, pend_in;
   logic [20:0] acc_ff, acc_in;
   logic [2:0]  exp_ff, exp_in;
   logic [15:0] char_ff, char_in;
   logic [15:0] byte_ff, byte_in;
   logic [15:0] start_ff, start_in;

   logic [1:0]  pend0, pend1;
   logic [20:0] acc0, acc1;
   logic [2:0]  exp0, exp1;
   logic [15:0] char0, char1, char2, byte0, start0, start1;
   logic        is_cont;
   logic        e1v, e2v, e3v;
   result_type  e1, e2, e3, slot0, slot1;
   logic [1:0]  n_res;

   // decode one byte against the (possibly restarted) state
   always_comb begin
      pend0  = first_byte ? 2'd0 : pend_ff;
      acc0   = first_byte ? 21'd0 : acc_ff;
      exp0   = first_byte ? 3'd0 : exp_ff;
      char0  = first_byte ? 16'd0 : char_ff;
      byte0  = first_byte ? 16'd0 : byte_ff;
      start0 = first_byte ? 16'd0 : start_ff;

      pend1  = pend0;
      acc1   = acc0;
      exp1   = exp0;
      start1 = start0;
      e1v    = 1'b0;
      e2v    = 1'b0;
      e3v    = 1'b0;
      e1     = '0;
      e2     = '0;
      e3     = '0;
      is_cont = (data_byte[7:6] == 2'b10);

      if (is_cont) begin
         // append payload; stray continuations are dropped
         if (pend0 != 2'd0) begin
            acc1  = {acc0[14:0], data_byte[5:0]};
            pend1 = pend0 - 2'd1;
            if (pend1 == 2'd0) begin
               e1v             = 1'b1;
               e1.code_point   = acc1;
               e1.start_offset = start0;
               e1.byte_length  = exp0;
               e1.status       = STATUS_OK;
               acc1            = '0;
               exp1            = '0;
            end
         end
      end else begin
         // a new lead cuts off an unfinished character
         if (pend0 != 2'd0) begin
            e1v             = 1'b1;
            e1.code_point   = acc0;
            e1.start_offset = start0;
            e1.byte_length  = exp0 - {1'b0, pend0};
            e1.status       = STATUS_TRUNC;
            pend1           = '0;
            acc1            = '0;
            exp1            = '0;
         end
         if (!data_byte[7]) begin
            e2v             = 1'b1;
            e2.code_point   = {13'd0, data_byte};
            e2.start_offset = byte0;
            e2.byte_length  = 3'd1;
            e2.status       = STATUS_OK;
         end else if (data_byte == LEAD_C0 || data_byte == LEAD_C1 ||
                      data_byte > LEAD_MAX) begin
            e2v             = 1'b1;
            e2.code_point   = {13'd0, data_byte};
            e2.start_offset = byte0;
            e2.byte_length  = 3'd1;
            e2.status       = STATUS_INVALID;
         end else begin
            if (data_byte[7:5] == 3'b110) begin
               exp1 = 3'd2;
               acc1 = {16'd0, data_byte[4:0]};
            end else if (data_byte[7:4] == 4'b1110) begin
               exp1 = 3'd3;
               acc1 = {17'd0, data_byte[3:0]};
            end else begin
               exp1 = 3'd4;
               acc1 = {18'd0, data_byte[2:0]};
            end
            pend1  = exp1[1:0] - 2'd1;
            start1 = byte0;
         end
      end

      // flush a partial character at the end of the string
      if (last_byte && pend1 != 2'd0) begin
         e3v             = 1'b1;
         e3.code_point   = acc1;
         e3.start_offset = start1;
         e3.byte_length  = exp1 - {1'b0, pend1};
         e3.status       = STATUS_TRUNC;
         pend1           = '0;
         acc1            = '0;
         exp1            = '0;
      end

      pend_in  = pend1;
      acc_in   = acc1;
      exp_in   = exp1;
      start_in = start1;
      byte_in  = (byte0 < COUNT_CAP) ? byte0 + 16'd1 : byte0;
   end

   // pack the emitted characters into two slots with running indexes
   always_comb begin
      char1 = (char0 < COUNT_CAP) ? char0 + 16'd1 : char0;
      char2 = (char1 < COUNT_CAP) ? char1 + 16'd1 : char1;
      n_res = 2'({1'b0, e1v} + {1'b0, e2v} + {1'b0, e3v});

      slot0 = e1v ? e1 : (e2v ? e2 : e3);
      slot1 = (e1v && e2v) ? e2 : e3;
      slot0.char_position = char0;
      slot0.is_target     = (char0 == target_index);
      slot0.run_end       = (n_res == 2'd1);
      slot1.char_position = char1;
      slot1.is_target     = (char1 == target_index);
      slot1.run_end       = 1'b1;

      case (n_res)
         2'd0:    char_in = char0;
         2'd1:    char_in = char1;
         default: char_in = char2;
      endcase

      dec_out.count = n_res;
      dec_out.res0  = slot0;
      dec_out.res1  = slot1;
   end

   // advance decoder state on each request
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         acc_ff   <= '0;
         exp_ff   <= '0;
         char_ff  <= '0;
         byte_ff  <= '0;
         start_ff <= '0;
      end else if (accept) begin
         pend_ff  <= pend_in;
         acc_ff   <= acc_in;
         exp_ff   <= exp_in;
         char_ff  <= char_in;
         byte_ff  <= byte_in;
         start_ff <= start_in;
      end
   end

endmodule

>>> rtl/utf8d_result_fifo.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Four-entry register queue; takes up to two results, gives one a cycle on pop.
// ----------------------------------------------------------------------------
module utf8d_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  utf8d_pkg::result_type push0,
   input  utf8d_pkg::result_type push1,
   input  logic                  pop,
   output utf8d_pkg::result_type head,
   output logic [2:0]            level
);
   import utf8d_pkg::*;

   result_type  entry_ff [4];
   logic [1:0]  wr_ff, wr_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  wr_next;

   // pointer and fill level
   always_comb begin
      wr_next  = wr_ff + 2'd1;
      wr_in    = wr_ff + push_count;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // store results in arrival order
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

   assign head  = entry_ff[rd_ff];
   assign level = count_ff;

endmodule

>>> rtl/utf8_stream_decoder.sv
// Results: a request accepted at a clock edge writes its results into the result
// queue there; rsp_tvalid shows them from the queue head, behind earlier results.
// Throughput: one byte per cycle while two result queue slots are free; a byte
// that yields two characters is absorbed by the four-entry result queue.
// Reset: synchronous, active high; clears decoder state, queue and target_index.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a UTF-8 byte stream into code points with index, offset and status.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder #(
   parameter int unsigned MAX_STRING_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [20:0] code_point, [36:21] char_position,
                                    // [52:37] start_offset, [55:53] byte_length,
                                    // [56] is_target, [63:57] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,   // run_end
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // target_index
);
   import utf8d_pkg::*;

   localparam int unsigned CapRaw = MAX_STRING_BYTES - 1;
   localparam logic [15:0] CountCap = (CapRaw > 65535) ? 16'hFFFF : 16'(CapRaw);

   logic [15:0]    target_ff;
   logic           accept;
   logic [1:0]     push_count;
   logic [2:0]     level;
   decode_out_type dec_out;
   result_type     head;

   // hold the target index
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // take a request while two queue slots are free
   assign req_tready = (level <= 3'd2);
   assign accept     = req_tvalid && req_tready;
   assign push_count = accept ? dec_out.count : 2'd0;

   utf8d_decode #(
      .COUNT_CAP(CountCap)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .first_byte  (req_tuser[0]),
      .last_byte   (req_tlast),
      .target_index(target_ff),
      .dec_out     (dec_out)
   );

   utf8d_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_count(push_count),
      .push0     (dec_out.res0),
      .push1     (dec_out.res1),
      .pop       (rsp_tvalid && rsp_tready),
      .head      (head),
      .level     (level)
   );

   // drive the result channel from the queue head
   assign rsp_tvalid = (level != 3'd0);
   assign rsp_tdata  = {7'd0, head.is_target, head.byte_length, head.start_offset,
                        head.char_position, head.code_point};
   assign rsp_tuser  = head.status;
   assign rsp_tlast  = head.run_end;

   `UTF8D_ASSERT(a_level_bound, clock, reset, level <= 3'd4)
   `UTF8D_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_tvalid)
   `UTF8D_ASSERT(a_invalid_single, clock, reset,
      (rsp_tvalid && head.status == STATUS_INVALID) |-> head.byte_length == 3'd1)
   `UTF8D_ASSERT(a_length_range, clock, reset,
      rsp_tvalid |-> (head.byte_length >= 3'd1 && head.byte_length <= 3'd4))

endmodule
